// ===== sv/http_message_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// http message header parser: assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_MESSAGE_HEADER_PARSER_DEFINES_SVH
`define HTTP_MESSAGE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define HMHP_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define HMHP_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== sv/hmhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hmhp_pkg
// Shared codes, keyword tables and the result record of the header parser.
// ----------------------------------------------------------------------------
package hmhp_pkg;

   // default header limit
   localparam int MAX_HEADERS_DEFAULT = 16;

   // stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;

   // byte roles
   localparam logic [3:0] ROLE_NONE    = 4'd0;
   localparam logic [3:0] ROLE_METHOD  = 4'd1;
   localparam logic [3:0] ROLE_TARGET  = 4'd2;
   localparam logic [3:0] ROLE_VERSION = 4'd3;
   localparam logic [3:0] ROLE_STATUS  = 4'd4;
   localparam logic [3:0] ROLE_REASON  = 4'd5;
   localparam logic [3:0] ROLE_HNAME   = 4'd6;
   localparam logic [3:0] ROLE_HVALUE  = 4'd7;
   localparam logic [3:0] ROLE_BODY    = 4'd8;

   // message kinds
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_REQUEST  = 2'd1;
   localparam logic [1:0] KIND_RESPONSE = 2'd2;

   // header kinds
   localparam logic [2:0] HK_UNKNOWN = 3'd0;

   // request status values
   localparam logic [15:0] STATUS_OK  = 16'd200;
   localparam logic [15:0] STATUS_BAD = 16'd400;

   // special characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // keyword table: version prefix, methods, then header names
   localparam int KW_COUNT        = 11;
   localparam int KW_HTTP         = 0;
   localparam int KW_FIRST_METHOD = 1;
   localparam int KW_LAST_METHOD  = 5;
   localparam int KW_FIRST_HEADER = 6;
   localparam int KW_MAX_LEN      = 14;
   localparam int KW_TEXT_W       = 8 * KW_MAX_LEN;

   localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
      KW_TEXT_W'("HTTP/"), KW_TEXT_W'("UNKNOWN"), KW_TEXT_W'("GET"),
      KW_TEXT_W'("POST"), KW_TEXT_W'("PUT"), KW_TEXT_W'("DELETE"),
      KW_TEXT_W'("Host"), KW_TEXT_W'("Content-Type"),
      KW_TEXT_W'("Content-Length"), KW_TEXT_W'("Connection"),
      KW_TEXT_W'("Accept")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd7, 4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd12, 4'd14, 4'd10, 4'd6
   };

   // character p of keyword k, counted from the first letter
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
      logic [3:0] off;
      off = KW_LEN[k] - 4'd1 - p;
      return KW_TEXT[k][{off, 3'b000} +: 8];
   endfunction

   // one result item
   typedef struct packed {
      logic [3:0]  role;
      logic [3:0]  header_index;
      logic        name_ended;
      logic [2:0]  header_kind;
      logic        done_res;
      logic        bad_message;
      logic [1:0]  message_type;
      logic [2:0]  method_code;
      logic [15:0] status_code;
      logic [4:0]  header_count;
   } rsp_type;

endpackage

// ===== sv/hmhp_parse_core.sv =====
// ----------------------------------------------------------------------------
// hmhp_parse_core
// Parse state and the per-byte step: word splitting, keyword matching,
// phase tracking, header counting and the end-of-message summary.
// ----------------------------------------------------------------------------
`include "http_message_header_parser_defines.svh"

module hmhp_parse_core #(
   parameter int MAX_HEADERS = hmhp_pkg::MAX_HEADERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output hmhp_pkg::rsp_type rsp
);

   localparam int HCW = $clog2(MAX_HEADERS + 2);

   typedef enum logic [3:0] {
      PH_METHOD  = 4'd1,
      PH_TARGET  = 4'd2,
      PH_VERSION = 4'd3,
      PH_STATUS  = 4'd4,
      PH_REASON  = 4'd5,
      PH_HNAME   = 4'd6,
      PH_HVALUE  = 4'd7,
      PH_BODY    = 4'd8,
      PH_ERR     = 4'd9
   } phase_type;

   typedef struct packed {
      phase_type       phase;
      logic            cr_pending;
      logic            in_word;
      logic [4:0]      word_pos;
      logic [10:0]     live;
      logic [15:0]     acc;
      logic [HCW-1:0]  hseen;
      logic            line_has_name;
      logic            version_seen;
      logic [1:0]      kind;
      logic [2:0]      method;
   } state_type;

   typedef struct packed {
      state_type       st;
      logic            name_ended;
      logic [2:0]      hkind;
      logic [HCW-1:0]  hidx;
   } work_type;

   localparam state_type ST_RESET = '{
      phase: PH_METHOD, cr_pending: 1'b0, in_word: 1'b0, word_pos: 5'd0,
      live: '1, acc: 16'd0, hseen: '0, line_has_name: 1'b0,
      version_seen: 1'b0, kind: hmhp_pkg::KIND_NONE, method: 3'd0
   };

   state_type state_ff;
   state_type state_in;

   // live keyword whose length equals the word so far
   function automatic logic kw_exact(input state_type s, input int k);
      return s.live[k] && (s.word_pos == 5'(hmhp_pkg::KW_LEN[k]));
   endfunction

   function automatic logic [3:0] phase_role(input phase_type ph);
      logic [3:0] r;
      unique case (ph)
         PH_METHOD:  r = hmhp_pkg::ROLE_METHOD;
         PH_TARGET:  r = hmhp_pkg::ROLE_TARGET;
         PH_VERSION: r = hmhp_pkg::ROLE_VERSION;
         PH_STATUS:  r = hmhp_pkg::ROLE_STATUS;
         PH_REASON:  r = hmhp_pkg::ROLE_REASON;
         PH_HNAME:   r = hmhp_pkg::ROLE_HNAME;
         PH_HVALUE:  r = hmhp_pkg::ROLE_HVALUE;
         PH_BODY:    r = hmhp_pkg::ROLE_BODY;
         default:    r = hmhp_pkg::ROLE_NONE;
      endcase
      return r;
   endfunction

   function automatic work_type start_word(input work_type w);
      w.st.in_word  = 1'b1;
      w.st.word_pos = 5'd0;
      w.st.live     = '1;
      if (w.st.phase == PH_STATUS) begin
         w.st.acc = 16'd0;
      end
      return w;
   endfunction

   // narrow the keyword candidates and take a status digit
   function automatic work_type feed_byte(input work_type w, input logic [7:0] b);
      logic [10:0] live;
      live = w.st.live;
      for (int k = 0; k < hmhp_pkg::KW_COUNT; k++) begin
         if (w.st.live[k]) begin
            if (w.st.word_pos < 5'(hmhp_pkg::KW_LEN[k])) begin
               if (b != hmhp_pkg::kw_char(4'(k), w.st.word_pos[3:0])) begin
                  live[k] = 1'b0;
               end
            end else if (k != hmhp_pkg::KW_HTTP) begin
               live[k] = 1'b0;
            end
         end
      end
      w.st.live = live;
      if (w.st.word_pos != 5'd31) begin
         w.st.word_pos = w.st.word_pos + 5'd1;
      end
      if (w.st.phase == PH_STATUS) begin
         w.st.acc = 16'(w.st.acc * 16'd10 + {8'd0, b} - {8'd0, hmhp_pkg::CH_ZERO});
      end
      return w;
   endfunction

   // close the current word and act on it by phase
   function automatic work_type finish_word(input work_type w);
      logic           found;
      logic [HCW-1:0] idx;
      found = 1'b0;
      if (w.st.in_word) begin
         w.st.in_word = 1'b0;
         unique case (w.st.phase)
            PH_METHOD: begin
               if (w.st.live[hmhp_pkg::KW_HTTP] &&
                   w.st.word_pos >= 5'(hmhp_pkg::KW_LEN[hmhp_pkg::KW_HTTP])) begin
                  w.st.kind  = hmhp_pkg::KIND_RESPONSE;
                  w.st.phase = PH_STATUS;
               end else begin
                  w.st.phase = PH_ERR;
                  for (int k = hmhp_pkg::KW_FIRST_METHOD; k <= hmhp_pkg::KW_LAST_METHOD;
                       k++) begin
                     if (!found && kw_exact(w.st, k)) begin
                        found       = 1'b1;
                        w.st.kind   = hmhp_pkg::KIND_REQUEST;
                        w.st.method = 3'(k - hmhp_pkg::KW_FIRST_METHOD);
                        w.st.phase  = PH_TARGET;
                     end
                  end
               end
            end
            PH_TARGET:  w.st.phase = PH_VERSION;
            PH_VERSION: w.st.version_seen = 1'b1;
            PH_STATUS:  w.st.phase = PH_REASON;
            PH_REASON:  w.st.line_has_name = 1'b1;
            PH_HNAME: begin
               // a name past the limit is counted but leaves the index alone
               idx        = w.st.hseen;
               w.st.hseen = w.st.hseen + HCW'(1);
               if (int'(idx) >= MAX_HEADERS) begin
                  w.st.phase = PH_ERR;
               end else begin
                  w.hidx       = idx;
                  w.name_ended = 1'b1;
                  w.hkind      = hmhp_pkg::HK_UNKNOWN;
                  for (int k = hmhp_pkg::KW_FIRST_HEADER; k < hmhp_pkg::KW_COUNT; k++) begin
                     if (!found && kw_exact(w.st, k)) begin
                        found   = 1'b1;
                        w.hkind = 3'(k - hmhp_pkg::KW_FIRST_HEADER + 1);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic work_type line_end(input work_type w);
      unique case (w.st.phase)
         PH_VERSION: w.st.phase = w.st.version_seen ? PH_HNAME : PH_ERR;
         PH_REASON:  w.st.phase = w.st.line_has_name ? PH_HNAME : PH_ERR;
         PH_HNAME:   w.st.phase = PH_BODY;
         PH_HVALUE:  w.st.phase = PH_HNAME;
         PH_BODY:    w.st.phase = PH_BODY;
         default:    w.st.phase = PH_ERR;
      endcase
      return w;
   endfunction

   // one byte through the parser
   always_comb begin : step_logic
      work_type        w;
      logic [3:0]      role;
      logic [HCW-1:0]  val_idx;
      logic            is_space;
      logic            bad;
      w.st         = state_ff;
      w.name_ended = 1'b0;
      w.hkind      = hmhp_pkg::HK_UNKNOWN;
      w.hidx       = '0;
      role         = hmhp_pkg::ROLE_NONE;
      val_idx      = (state_ff.hseen != '0) ? state_ff.hseen - HCW'(1) : '0;
      is_space     = (data_byte == hmhp_pkg::CH_SP) || (data_byte == hmhp_pkg::CH_TAB) ||
                     (data_byte == hmhp_pkg::CH_VT) || (data_byte == hmhp_pkg::CH_FF);

      if (w.st.phase != PH_ERR) begin
         if (w.st.cr_pending) begin
            // only a line feed may follow a carriage return
            w.st.cr_pending = 1'b0;
            if (data_byte != hmhp_pkg::CH_LF) begin
               w.st.phase = PH_ERR;
            end else begin
               role = (w.st.phase == PH_BODY) ? hmhp_pkg::ROLE_BODY : hmhp_pkg::ROLE_NONE;
               w = line_end(w);
            end
         end else if (data_byte == hmhp_pkg::CH_NUL) begin
            w.st.phase = PH_ERR;
         end else if (data_byte == hmhp_pkg::CH_CR) begin
            w = finish_word(w);
            if (w.st.phase != PH_ERR) begin
               role = (w.st.phase == PH_BODY) ? hmhp_pkg::ROLE_BODY : hmhp_pkg::ROLE_NONE;
               w.st.cr_pending = 1'b1;
               if (last_byte) begin
                  w.st.phase = PH_ERR;
               end
            end
         end else if (data_byte == hmhp_pkg::CH_LF) begin
            w = finish_word(w);
            role = (w.st.phase == PH_BODY) ? hmhp_pkg::ROLE_BODY : hmhp_pkg::ROLE_NONE;
            w = line_end(w);
         end else if (is_space) begin
            w = finish_word(w);
            role = (w.st.phase == PH_BODY) ? hmhp_pkg::ROLE_BODY : hmhp_pkg::ROLE_NONE;
         end else if (data_byte == hmhp_pkg::CH_COLON) begin
            // colon ends a header name, elsewhere it is a word of its own
            w = finish_word(w);
            if (w.st.phase == PH_HNAME) begin
               w.st.phase = PH_HVALUE;
            end else if (w.st.phase != PH_ERR) begin
               role = phase_role(w.st.phase);
               if (role == hmhp_pkg::ROLE_HVALUE) begin
                  w.hidx = val_idx;
               end
               w = start_word(w);
               w = feed_byte(w, data_byte);
               w = finish_word(w);
            end
         end else begin
            // ordinary word byte
            if (!w.st.in_word) begin
               w = start_word(w);
            end
            role = phase_role(w.st.phase);
            if (role == hmhp_pkg::ROLE_HNAME) begin
               w.hidx = w.st.hseen;
            end else if (role == hmhp_pkg::ROLE_HVALUE) begin
               w.hidx = val_idx;
            end
            w = feed_byte(w, data_byte);
            if (last_byte) begin
               w = finish_word(w);
            end
         end
      end

      // per-byte fields
      rsp.role         = role;
      rsp.header_index = 4'(w.hidx);
      rsp.name_ended   = w.name_ended;
      rsp.header_kind  = w.hkind;

      // end-of-message summary
      bad                 = (w.st.phase == PH_ERR);
      rsp.done_res        = last_byte;
      rsp.bad_message     = last_byte && bad;
      rsp.message_type    = last_byte ? w.st.kind : hmhp_pkg::KIND_NONE;
      rsp.method_code     = last_byte ? w.st.method : 3'd0;
      rsp.header_count    = last_byte ? 5'(w.st.hseen) : 5'd0;
      rsp.status_code     = 16'd0;
      if (last_byte) begin
         if (w.st.kind == hmhp_pkg::KIND_REQUEST) begin
            rsp.status_code = bad ? hmhp_pkg::STATUS_BAD : hmhp_pkg::STATUS_OK;
         end else if (w.st.kind == hmhp_pkg::KIND_RESPONSE) begin
            rsp.status_code = w.st.acc;
         end
      end

      // a finished message returns to the reset state
      state_in = last_byte ? ST_RESET : w.st;
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RESET;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   `HMHP_ASSERT_IMP(a_err_role_none, step_en && (state_ff.phase == PH_ERR), rsp.role == hmhp_pkg::ROLE_NONE, "byte after an error carries a role")
   `HMHP_ASSERT_IMP(a_kind_needs_name, rsp.header_kind != hmhp_pkg::HK_UNKNOWN, rsp.name_ended, "header kind without a completed name")
   `HMHP_ASSERT_NXT(a_last_resets, step_en && last_byte, state_ff.phase == PH_METHOD, "parser not back in method phase after last byte")
   `HMHP_ASSERT_IMP(a_hseen_bound, 1'b1, int'(state_ff.hseen) <= MAX_HEADERS + 1, "header counter beyond limit plus one")

endmodule

// ===== sv/http_message_header_parser.sv =====
// ----------------------------------------------------------------------------
// http_message_header_parser
// Streaming parser for HTTP/1.1 start lines and headers. Takes one message
// byte per item on req_ and returns one result item per byte on rsp_: the
// byte's role, header index and kind when a header name completes, and on
// the byte flagged by req_tlast a summary (message type, method, status,
// header count, error flag), with rsp_tlast set. One byte is accepted every
// cycle while results are taken. A byte goes from the input register to the
// result register once the result register is free or being taken; the parse
// state update in hmhp_parse_core handles each byte completely. A held result
// stalls the input once the input register is full too. The parser returns to
// its reset state after each final byte.
// ----------------------------------------------------------------------------
`include "http_message_header_parser_defines.svh"

module http_message_header_parser #(
   parameter int MAX_HEADERS = hmhp_pkg::MAX_HEADERS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // message bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hmhp_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // last_byte
   // per-byte results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] role, [7:4] header_index, [8] name_ended, [11:9] header_kind,
   // [12] bad_message, [14:13] message_type, [17:15] method_code,
   // [33:18] status_code, [38:34] header_count, [39] zero
   output logic [hmhp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast    // done_res
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [7:0]                        in_data_ff;
   logic                              in_last_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [hmhp_pkg::RSP_TDATA_W-1:0]  out_data_ff;
   logic [hmhp_pkg::RSP_TDATA_W-1:0]  out_data_in;
   logic                              out_last_ff;
   logic                              advance;
   hmhp_pkg::rsp_type                 rsp;

   // handshake: the input register moves on when the result register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // per-byte parse step
   hmhp_parse_core #(
      .MAX_HEADERS (MAX_HEADERS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .rsp       (rsp)
   );

   // result packing, first field lowest
   assign out_data_in = {1'b0, rsp.header_count, rsp.status_code, rsp.method_code,
                         rsp.message_type, rsp.bad_message, rsp.header_kind,
                         rsp.name_ended, rsp.header_index, rsp.role};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= rsp.done_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `HMHP_ASSERT_NXT(a_step_fills_out, advance, out_valid_ff, "stepped item did not reach the result register")
   `HMHP_ASSERT_IMP(a_full_blocks_in, in_valid_ff && out_valid_ff && !rsp_tready, !req_tready, "input taken while both registers are held")

endmodule
